### design/hdrtm_pkg.sv
// ----------------------------------------------------------------------------
// hdrtm_pkg
// Shared widths and register codes for the HDR tone map pixel unit.
// ----------------------------------------------------------------------------
package hdrtm_pkg;

	localparam int VAL_W   = 24;
	localparam int OUT_W   = 8;
	localparam int CHAN_N  = 3;
	localparam int IN_N    = 10;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [OUT_W-1:0] pix_t;

	typedef enum logic [0:0] {
		REG_GLOW_LEVEL = 1'b0
	} reg_idx_t;

endpackage

### design/hdrtm_gamma_rom.sv
// ----------------------------------------------------------------------------
// hdrtm_gamma_rom
// Gamma 1/2.2 curve ROM, contents built at elaboration, registered read.
// ----------------------------------------------------------------------------
module hdrtm_gamma_rom #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [ADDR_W-1:0]          addr,
	output hdrtm_pkg::pix_t            q
);

	typedef hdrtm_pkg::pix_t tab_t [DEPTH];

	function automatic logic [199:0] ipow(input logic [199:0] base, input int e);
		logic [199:0] r;
		r = 200'd1;
		for (int k = 0; k < e; k++) begin
			r = r * base;
		end
		return r;
	endfunction

	function automatic tab_t build_tab();
		tab_t t;
		logic [199:0] rhs;
		logic [199:0] lhs;
		logic [199:0] nterm;
		logic [199:0] kterm;
		int y;
		y = 0;
		nterm = ipow(200'(DEPTH - 1), 5);
		kterm = ipow(200'd510, 11);
		for (int i = 0; i < DEPTH; i++) begin
			rhs = ipow(200'(i), 5) * kterm;
			for (int s = 0; s < 256; s++) begin
				if (y < 255) begin
					lhs = ipow(200'(2 * (y + 1) - 1), 11) * nterm;
					if (lhs <= rhs)
						y = y + 1;
				end
			end
			t[i] = hdrtm_pkg::OUT_W'(y);
		end
		return t;
	endfunction

	localparam tab_t TAB = build_tab();

	always_ff @(posedge clk) begin
		if (en)
			q <= TAB[addr];
	end

endmodule

### design/hdr_tonemap_gamma_pixel_unit.sv
// ----------------------------------------------------------------------------
// hdr_tonemap_gamma_pixel_unit
// Per-pixel light/bloom/background/firelight mix, Reinhard map, gamma ROM.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel per transaction: ten UQ8.16 fields in s_tdata.
//   m_* returns one transaction per pixel: three gamma-corrected 8-bit
//   channels and the three lights decayed by 0.55.
//   APB register 0 (glow_level, 24 bits) resets to 1.0; write it only when
//   the pipeline is empty.
// Pipeline: five multiply/sum stages, one stage per quotient bit of the
//   restoring divider for v/(1+v), and the registered gamma ROM read.
// Throughput: one pixel per cycle unless m_* stalls; the whole pipeline advances together.
// Stall: while m_tvalid is high and m_tready low, every stage holds and
//   s_tready is low; nothing is dropped or repeated.
// Reset: arst_n clears all valid bits and resets the register to 1.0.
// ----------------------------------------------------------------------------
module hdr_tonemap_gamma_pixel_unit #(
	parameter int GAMMA_LUT_SIZE = 1024,
	parameter int FRAC_BITS      = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// light_red, light_green, light_blue, bloom_red, bloom_green, bloom_blue,
	// back_red, back_green, back_blue, fire_weight (24 bits each)
	input  logic [239:0] s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// out_red, out_green, out_blue (8 bits each),
	// decayed_red, decayed_green, decayed_blue (24 bits each)
	output logic [95:0]  m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int VW   = hdrtm_pkg::VAL_W;
	localparam int CN   = hdrtm_pkg::CHAN_N;
	localparam int KW   = FRAC_BITS + 1;
	localparam int IW   = $clog2(GAMMA_LUT_SIZE);
	localparam int NST  = 6 + IW;
	localparam int DENW = VW + 2;
	localparam int NUMW = VW + IW;
	localparam int RW   = DENW + IW;
	localparam longint KEXP_L = ((longint'(105) << FRAC_BITS) + 50) / 100;
	localparam longint KBLM_L = ((longint'(34) << FRAC_BITS) + 50) / 100;
	localparam longint KDEC_L = ((longint'(55) << FRAC_BITS) + 50) / 100;
	localparam longint KFG_L  = ((longint'(40) << FRAC_BITS) + 50) / 100;
	localparam longint KFB_L  = ((longint'(12) << FRAC_BITS) + 50) / 100;
	localparam longint ONE_L  = longint'(1) << FRAC_BITS;
	localparam logic [KW-1:0] KEXP = KW'(KEXP_L);
	localparam logic [KW-1:0] KBLM = KW'(KBLM_L);
	localparam logic [KW-1:0] KDEC = KW'(KDEC_L);
	localparam logic [KW-1:0] KFIRE [CN] = '{KW'(ONE_L), KW'(KFG_L), KW'(KFB_L)};
	localparam logic [VW-1:0] GLOW_RST = VW'(ONE_L & longint'(24'hFFFFFF));
	localparam logic [VW-1:0] VMAX = '1;
	localparam logic [IW:0]   LUT_LAST = (IW+1)'(GAMMA_LUT_SIZE - 1);

	logic                     adv;
	logic [NST-1:0]           vld_q;
	logic [VW-1:0]            glow_q;
	logic                     reg_hit;

	// stage 1: products
	logic [2*VW-1:0]          warm_p_s1;
	logic [VW+KW-1:0]         exp_p_s1 [CN];
	logic [VW+KW-1:0]         blm_p_s1 [CN];
	logic [VW+KW-1:0]         dec_p_s1 [CN];
	logic [VW-1:0]            back_s1  [CN];
	// stage 2
	logic [VW-1:0]            warm_s2;
	logic [VW:0]              exp_s2   [CN];
	logic [VW-1:0]            blm_s2   [CN];
	logic [VW-1:0]            dec_s2   [CN];
	logic [VW-1:0]            back_s2  [CN];
	// stage 3
	logic [VW+KW-1:0]         fire_p_s3 [CN];
	logic [VW:0]              exp_s3   [CN];
	logic [VW-1:0]            blm_s3   [CN];
	logic [VW-1:0]            dec_s3   [CN];
	logic [VW-1:0]            back_s3  [CN];
	// stage 4
	logic [VW-1:0]            v_s4     [CN];
	logic [VW-1:0]            dec_s4   [CN];
	// stage 5 and divider stages
	logic [RW-1:0]            rem_s5   [IW+1][CN];
	logic [DENW-1:0]          den_s5   [IW+1][CN];
	logic [IW-1:0]            quo_s5   [IW+1][CN];
	logic [VW-1:0]            dec_s5   [IW+1][CN];
	// rom stage
	logic [VW-1:0]            dec_sr   [CN];
	hdrtm_pkg::pix_t          pix_sr   [CN];

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign pready   = 1'b1;
	assign reg_hit  = (hdrtm_pkg::reg_idx_t'(paddr[2]) == hdrtm_pkg::REG_GLOW_LEVEL);
	assign prdata   = reg_hit ? 32'(glow_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glow_q <= GLOW_RST;
		end else if (psel && penable && pwrite && reg_hit) begin
			glow_q <= pwdata[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			warm_p_s1 <= s_tdata[239:216] * glow_q;
			for (int c = 0; c < CN; c++) begin
				exp_p_s1[c] <= s_tdata[c*VW +: VW] * KEXP;
				blm_p_s1[c] <= s_tdata[(3+c)*VW +: VW] * KBLM;
				dec_p_s1[c] <= s_tdata[c*VW +: VW] * KDEC;
				back_s1[c]  <= s_tdata[(6+c)*VW +: VW];
			end

			warm_s2 <= ((warm_p_s1 >> FRAC_BITS) > (2*VW)'(VMAX)) ? VMAX
				: VW'(warm_p_s1 >> FRAC_BITS);
			for (int c = 0; c < CN; c++) begin
				exp_s2[c]  <= (VW+1)'(exp_p_s1[c] >> FRAC_BITS);
				blm_s2[c]  <= VW'(blm_p_s1[c] >> FRAC_BITS);
				dec_s2[c]  <= ((dec_p_s1[c] >> FRAC_BITS) > (VW+KW)'(VMAX)) ? VMAX
					: VW'(dec_p_s1[c] >> FRAC_BITS);
				back_s2[c] <= back_s1[c];
			end

			for (int c = 0; c < CN; c++) begin
				fire_p_s3[c] <= warm_s2 * KFIRE[c];
				exp_s3[c]    <= exp_s2[c];
				blm_s3[c]    <= blm_s2[c];
				dec_s3[c]    <= dec_s2[c];
				back_s3[c]   <= back_s2[c];
			end

			for (int c = 0; c < CN; c++) begin
				logic [VW+2:0] sum;
				sum = (VW+3)'(exp_s3[c]) + (VW+3)'(blm_s3[c]) + (VW+3)'(back_s3[c])
					+ (VW+3)'(fire_p_s3[c] >> FRAC_BITS);
				v_s4[c]   <= (sum > (VW+3)'(VMAX)) ? VMAX : VW'(sum);
				dec_s4[c] <= dec_s3[c];
			end

			for (int c = 0; c < CN; c++) begin
				rem_s5[0][c] <= RW'(NUMW'(v_s4[c]) * NUMW'(GAMMA_LUT_SIZE - 1));
				den_s5[0][c] <= DENW'(ONE_L) + DENW'(v_s4[c]);
				quo_s5[0][c] <= '0;
				dec_s5[0][c] <= dec_s4[c];
			end
		end
	end

	for (genvar k = 1; k <= IW; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int c = 0; c < CN; c++) begin
					logic [RW-1:0] cand;
					cand = RW'(den_s5[k-1][c]) << (IW - k);
					if (rem_s5[k-1][c] >= cand) begin
						rem_s5[k][c] <= rem_s5[k-1][c] - cand;
						quo_s5[k][c] <= quo_s5[k-1][c] | (IW'(1) << (IW - k));
					end else begin
						rem_s5[k][c] <= rem_s5[k-1][c];
						quo_s5[k][c] <= quo_s5[k-1][c];
					end
					den_s5[k][c] <= den_s5[k-1][c];
					dec_s5[k][c] <= dec_s5[k-1][c];
				end
			end
		end
	end

	for (genvar c = 0; c < CN; c++) begin : g_rom
		logic [IW-1:0] idx;
		assign idx = ((IW+1)'(quo_s5[IW][c]) > LUT_LAST) ? LUT_LAST[IW-1:0]
			: quo_s5[IW][c];
		hdrtm_gamma_rom #(
			.DEPTH  (GAMMA_LUT_SIZE),
			.ADDR_W (IW)
		) u_rom (
			.clk  (clk),
			.en   (adv),
			.addr (idx),
			.q    (pix_sr[c])
		);
		always_ff @(posedge clk) begin
			if (adv)
				dec_sr[c] <= dec_s5[IW][c];
		end
	end

	assign m_tvalid = vld_q[NST-1];
	assign m_tdata  = {dec_sr[2], dec_sr[1], dec_sr[0], pix_sr[2], pix_sr[1], pix_sr[0]};

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(vld_q))
		else $error("pipeline moved during stall");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NST-2] |-> ((IW+1)'(quo_s5[IW][0]) < LUT_LAST))
		else $error("tone map index out of range");

	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken during stall");

endmodule
